// ===== hw/rtl/ppid_pkg.sv =====
// ----------------------------------------------------------------------------
// ppid_pkg
// Shared widths, register indexes and reset values for the pan position PID.
// ----------------------------------------------------------------------------
`default_nettype none

package ppid_pkg;

  // Field widths
  localparam int POS_W     = 11;  // encoder position
  localparam int IVL_W     = 16;  // run interval / tick countdown
  localparam int GAIN_W    = 12;  // unsigned Q2.10 gain
  localparam int LIM_W     = 15;  // integrator and speed limits
  localparam int SUM_W     = 16;  // signed integrator
  localparam int SPEED_W   = 16;  // signed speed command
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int FRAC_W    = 10;  // Q2.10 fraction bits

  // Parameter defaults
  localparam int RATE_FACTOR_DEF = 25;
  localparam int REV_TICKS_DEF   = 1080;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RUN_INTERVAL = 3'd0,
    REG_BAND_START   = 3'd1,
    REG_BAND_STOP    = 3'd2,
    REG_PROP_GAIN    = 3'd3,
    REG_INTEG_GAIN   = 3'd4,
    REG_DERIV_GAIN   = 3'd5,
    REG_INTEG_LIMIT  = 3'd6,
    REG_MAX_SPEED    = 3'd7
  } cfg_reg_t;

  // Reset values
  localparam logic [IVL_W-1:0]  RUN_INTERVAL_RST = 16'd200;
  localparam logic [POS_W-1:0]  BAND_START_RST   = 11'd205;
  localparam logic [POS_W-1:0]  BAND_STOP_RST    = 11'd860;
  localparam int                PROP_GAIN_RST    = 635;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST   = 12'd614;
  localparam int                DERIV_GAIN_RST   = 0;
  localparam logic [LIM_W-1:0]  INTEG_LIMIT_RST  = 15'd1250;
  localparam logic [LIM_W-1:0]  MAX_SPEED_RST    = 15'd1500;

endpackage

`default_nettype wire

// ===== hw/rtl/pan_position_pid.sv =====
// ----------------------------------------------------------------------------
// pan_position_pid
// Pan position PID loop run every run_interval scheduler ticks.
// ----------------------------------------------------------------------------
// Every input item is one scheduler tick; the block accepts a tick in every
// cycle unless the result side stalls. A 16-bit down counter picks out one
// tick in run_interval (interval 0 means one in 65536); only that tick
// yields a speed item, the others yield nothing. The loop state (countdown,
// integrator, previous error) is updated in the error and integrator stage,
// so runs may follow each other in consecutive cycles. A result passes
// through the input register, error and integrator stage, gain products,
// PID sum, magnitude and range clamp, and the output register, which takes
// the division by RATE_FACTOR through a reciprocal product and the
// max_speed clamp. The stages hold their items under back-pressure and
// close up bubbles. The P and D gains are folded with RATE_FACTOR when
// written, so configure only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module pan_position_pid
  import ppid_pkg::*;
#(
  parameter int RATE_FACTOR      = RATE_FACTOR_DEF,
  parameter int REVOLUTION_TICKS = REV_TICKS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DAT_W-1:0]  cfg_wdata,
  // tick items in
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [POS_W-1:0]      in_current_position,
  input  wire logic [POS_W-1:0]      in_target_position,
  input  wire logic                  in_target_valid,
  // speed items out
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [SPEED_W-1:0]  out_speed
);

  // --------------------------------------------------------------------------
  // Derived sizes
  // --------------------------------------------------------------------------
  // wrapped error: |target - current| <= 2047, plus one revolution
  localparam int ERR_W  = $clog2(2048 + REVOLUTION_TICKS + 1) + 1;
  localparam int HALF   = REVOLUTION_TICKS / 2;
  localparam int DERR_W = ERR_W + 1;                 // err - prev_error
  localparam int SUMX_W = ((SUM_W > ERR_W) ? SUM_W : ERR_W) + 1;
  // gains pre-scaled by RATE_FACTOR (P) and RATE_FACTOR^2 (D)
  localparam int KP_W   = GAIN_W + $clog2(RATE_FACTOR + 1);
  localparam int KD_W   = GAIN_W + $clog2(RATE_FACTOR * RATE_FACTOR + 1);
  localparam int PP_W   = ERR_W + KP_W + 1;
  localparam int IP_W   = SUM_W + GAIN_W + 1;
  localparam int DP_W   = DERR_W + KD_W + 1;
  localparam int MAXP_W = (PP_W > IP_W) ? ((PP_W > DP_W) ? PP_W : DP_W)
                                        : ((IP_W > DP_W) ? IP_W : DP_W);
  localparam int NUM_W  = MAXP_W + 2;
  localparam int QW     = NUM_W - FRAC_W;
  // anything at or above 32768*RATE_FACTOR saturates any max_speed
  localparam int QN     = $clog2(32768 * RATE_FACTOR);
  localparam longint unsigned QMAX = 64'(32768 * RATE_FACTOR - 1);
  localparam int LOG_RF = $clog2(RATE_FACTOR);
  localparam int SH     = QN + LOG_RF;
  localparam int RW     = QN + 1;
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + 64'(RATE_FACTOR) - 64'd1) / 64'(RATE_FACTOR);
  localparam int MAG_W  = SPEED_W - 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [IVL_W-1:0]  run_interval_r;
  logic [POS_W-1:0]  band_start_r;
  logic [POS_W-1:0]  band_stop_r;
  logic [KP_W-1:0]   kp_r;          // prop_gain * RATE_FACTOR
  logic [GAIN_W-1:0] ki_r;
  logic [KD_W-1:0]   kd_r;          // deriv_gain * RATE_FACTOR^2
  logic [LIM_W-1:0]  integ_limit_r;
  logic [LIM_W-1:0]  max_speed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_interval_r <= RUN_INTERVAL_RST;
      band_start_r   <= BAND_START_RST;
      band_stop_r    <= BAND_STOP_RST;
      kp_r           <= KP_W'(PROP_GAIN_RST * RATE_FACTOR);
      ki_r           <= INTEG_GAIN_RST;
      kd_r           <= KD_W'(DERIV_GAIN_RST * RATE_FACTOR * RATE_FACTOR);
      integ_limit_r  <= INTEG_LIMIT_RST;
      max_speed_r    <= MAX_SPEED_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_RUN_INTERVAL: run_interval_r <= cfg_wdata[IVL_W-1:0];
        REG_BAND_START:   band_start_r   <= cfg_wdata[POS_W-1:0];
        REG_BAND_STOP:    band_stop_r    <= cfg_wdata[POS_W-1:0];
        REG_PROP_GAIN:    kp_r <= KP_W'(cfg_wdata[GAIN_W-1:0]) * KP_W'(RATE_FACTOR);
        REG_INTEG_GAIN:   ki_r           <= cfg_wdata[GAIN_W-1:0];
        REG_DERIV_GAIN:   kd_r <= KD_W'(cfg_wdata[GAIN_W-1:0])
                                  * KD_W'(RATE_FACTOR * RATE_FACTOR);
        REG_INTEG_LIMIT:  integ_limit_r  <= cfg_wdata[LIM_W-1:0];
        REG_MAX_SPEED:    max_speed_r    <= cfg_wdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control: a stage takes a new item when it is empty or its
  // own item moves on.
  // --------------------------------------------------------------------------
  logic s0_vld_r, s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, out_vld_r;
  logic out_rdy, s4_rdy, s3_rdy, s2_rdy, s1_rdy, s0_rdy;

  assign out_rdy = !out_vld_r || !out_stall;
  assign s4_rdy  = !s4_vld_r || out_rdy;
  assign s3_rdy  = !s3_vld_r || s4_rdy;
  assign s2_rdy  = !s2_vld_r || s3_rdy;
  assign s1_rdy  = !s1_vld_r || s2_rdy;
  assign s0_rdy  = !s0_vld_r || s1_rdy;

  assign in_stall  = !s0_rdy;
  assign out_valid = out_vld_r;

  // --------------------------------------------------------------------------
  // Stage 0: input register
  // --------------------------------------------------------------------------
  logic [POS_W-1:0] cur_s0_r;
  logic [POS_W-1:0] tgt_s0_r;
  logic             tvld_s0_r;

  always_ff @(posedge clk) begin
    if (s0_rdy) begin
      cur_s0_r  <= in_current_position;
      tgt_s0_r  <= in_target_position;
      tvld_s0_r <= in_target_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: tick counting, target shaping, wrapped error, integrator.
  // Loop state lives here so back-to-back runs see each other's update.
  // --------------------------------------------------------------------------
  logic [IVL_W-1:0]         countdown_r, countdown_nxt, count_dec;
  logic signed [SUM_W-1:0]  esum_r, esum_nxt;
  logic signed [POS_W-1:0]  prev_err_r, prev_err_nxt;
  logic                     run, s0_move;
  logic [POS_W-1:0]         tgt, tgt_snap;
  logic [POS_W:0]           band_mid;
  logic signed [ERR_W-1:0]  diff, err;
  logic signed [SUMX_W-1:0] esum_raw;
  logic signed [SUMX_W-1:0] lim_pos, lim_neg;
  logic signed [DERR_W-1:0] derr;

  assign s0_move   = s0_vld_r && s1_rdy;
  assign count_dec = countdown_r - IVL_W'(1);
  assign run       = (count_dec == '0);

  always_comb begin
    countdown_nxt = run ? run_interval_r : count_dec;

    // absent target reads as zero; a target inside the band goes to band_start
    // when below the rounded-down band middle, else to band_stop
    tgt      = tvld_s0_r ? tgt_s0_r : '0;
    band_mid = ({1'b0, band_start_r} + {1'b0, band_stop_r}) >> 1;
    tgt_snap = tgt;
    if (tgt > band_start_r && tgt < band_stop_r) begin
      tgt_snap = ({1'b0, tgt} < band_mid) ? band_start_r : band_stop_r;
    end

    // shortest way round one revolution
    diff = ERR_W'($signed({1'b0, tgt_snap})) - ERR_W'($signed({1'b0, cur_s0_r}));
    err  = diff;
    if (diff > ERR_W'(HALF)) begin
      err = diff - ERR_W'(REVOLUTION_TICKS);
    end else if (diff < -ERR_W'(HALF)) begin
      err = diff + ERR_W'(REVOLUTION_TICKS);
    end

    // clamped integrator
    esum_raw = SUMX_W'(esum_r) + SUMX_W'(err);
    lim_pos  = SUMX_W'($signed({1'b0, integ_limit_r}));
    lim_neg  = -lim_pos;
    if (esum_raw > lim_pos) begin
      esum_nxt = SUM_W'(lim_pos);
    end else if (esum_raw < lim_neg) begin
      esum_nxt = SUM_W'(lim_neg);
    end else begin
      esum_nxt = SUM_W'(esum_raw);
    end

    derr         = DERR_W'(err) - DERR_W'(prev_err_r);
    prev_err_nxt = err[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      countdown_r <= RUN_INTERVAL_RST;
      esum_r      <= '0;
      prev_err_r  <= '0;
    end else if (s0_move) begin
      countdown_r <= countdown_nxt;
      if (run) begin
        esum_r     <= esum_nxt;
        prev_err_r <= prev_err_nxt;
      end
    end
  end

  logic signed [ERR_W-1:0]  err_s1_r;
  logic signed [SUM_W-1:0]  esum_s1_r;
  logic signed [DERR_W-1:0] derr_s1_r;

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      err_s1_r  <= err;
      esum_s1_r <= esum_nxt;
      derr_s1_r <= derr;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: gain products
  // --------------------------------------------------------------------------
  logic signed [PP_W-1:0] pterm_s2_r;
  logic signed [IP_W-1:0] iterm_s2_r;
  logic signed [DP_W-1:0] dterm_s2_r;

  always_ff @(posedge clk) begin
    if (s2_rdy) begin
      pterm_s2_r <= PP_W'(err_s1_r)  * PP_W'($signed({1'b0, kp_r}));
      iterm_s2_r <= IP_W'(esum_s1_r) * IP_W'($signed({1'b0, ki_r}));
      dterm_s2_r <= DP_W'(derr_s1_r) * DP_W'($signed({1'b0, kd_r}));
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: PID sum, scaled by 1024 * RATE_FACTOR
  // --------------------------------------------------------------------------
  logic signed [NUM_W-1:0] num_s3_r;

  always_ff @(posedge clk) begin
    if (s3_rdy) begin
      num_s3_r <= NUM_W'(pterm_s2_r) + NUM_W'(iterm_s2_r) + NUM_W'(dterm_s2_r);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: magnitude, drop fraction, clamp to the range that can matter
  // --------------------------------------------------------------------------
  logic [NUM_W-1:0] num_mag;
  logic [QW-1:0]    q_raw;
  logic [QN-1:0]    q_clamp;
  logic             neg_s4_r;
  logic [QN-1:0]    q_s4_r;

  always_comb begin
    num_mag = num_s3_r[NUM_W-1] ? NUM_W'(-num_s3_r) : NUM_W'(num_s3_r);
    q_raw   = num_mag[NUM_W-1:FRAC_W];
    q_clamp = (64'(q_raw) > QMAX) ? QN'(QMAX) : q_raw[QN-1:0];
  end

  always_ff @(posedge clk) begin
    if (s4_rdy) begin
      neg_s4_r <= num_s3_r[NUM_W-1];
      q_s4_r   <= q_clamp;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: divide by RATE_FACTOR (exact reciprocal product, then shift),
  // max_speed clamp and sign, into the output register
  // --------------------------------------------------------------------------
  logic [QN+RW-1:0]         recip_prod;
  logic [MAG_W-1:0]         quot, mag;
  logic signed [SPEED_W-1:0] speed_nxt;
  logic signed [SPEED_W-1:0] speed_r;

  always_comb begin
    recip_prod = (QN+RW)'(q_s4_r) * (QN+RW)'(RW'(RECIP));
    quot       = recip_prod[SH +: MAG_W];
    mag        = (quot > max_speed_r) ? max_speed_r : quot;
    speed_nxt  = neg_s4_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      speed_r <= speed_nxt;
    end
  end

  assign out_speed = speed_r;

  // --------------------------------------------------------------------------
  // Stage valid bits; only a run tick enters stage 1
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r  <= 1'b0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (s0_rdy)  s0_vld_r  <= in_valid;
      if (s1_rdy)  s1_vld_r  <= s0_vld_r && run;
      if (s2_rdy)  s2_vld_r  <= s1_vld_r;
      if (s3_rdy)  s3_vld_r  <= s2_vld_r;
      if (s4_rdy)  s4_vld_r  <= s3_vld_r;
      if (out_rdy) out_vld_r <= s4_vld_r;
    end
  end

endmodule

`default_nettype wire

// ===== tb/pan_position_pid_checker.sv =====
// ----------------------------------------------------------------------------
// pan_position_pid_checker
// Watches the configuration port and both item channels of pan_position_pid.
// It keeps its own copy of the registers and loop state, predicts the speed
// item of every controller run and compares each speed item as it leaves.
// ----------------------------------------------------------------------------
module pan_position_pid_checker
  import ppid_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DAT_W-1:0]      cfg_wdata,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [POS_W-1:0]          in_current_position,
  input  logic [POS_W-1:0]          in_target_position,
  input  logic                      in_target_valid,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic signed [SPEED_W-1:0] out_speed,
  output int                        runs_predicted,
  output int                        speeds_pending,
  output int                        fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RATE = RATE_FACTOR_DEF;
  localparam int REV  = REV_TICKS_DEF;

  // register copies
  int run_interval;
  int band_start;
  int band_stop;
  int prop_gain;
  int integ_gain;
  int deriv_gain;
  int integ_limit;
  int max_speed;

  // loop state
  logic [IVL_W-1:0]          countdown;
  int                        prev_err;
  int                        err_sum;
  logic signed [SPEED_W-1:0] speed_q[$];

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // One controller run; updates integrator and previous error.
  function automatic logic signed [SPEED_W-1:0] loop_speed(int cur, int tgt, bit tgt_ok);
    int                    err;
    int                    mid;
    longint                acc;
    logic signed [POS_W-1:0] err_low;
    if (!tgt_ok) tgt = 0;
    if (tgt > band_start && tgt < band_stop) begin
      mid = (band_start + band_stop) / 2;
      tgt = (tgt < mid) ? band_start : band_stop;
    end
    err = tgt - cur;
    if (err > REV / 2) err -= REV;
    else if (err < -(REV / 2)) err += REV;
    err_sum = int'(clamp_sym(longint'(err_sum) + err, integ_limit));
    acc = longint'(err) * prop_gain * RATE + longint'(err_sum) * integ_gain
        + longint'(err - prev_err) * RATE * RATE * deriv_gain;
    // truncation toward zero, then the speed clamp
    acc = clamp_sym(acc / (1024 * RATE), max_speed);
    err_low = err[POS_W-1:0];
    prev_err = int'(err_low);
    return acc[SPEED_W-1:0];
  endfunction

  always @(posedge clk) begin : watch
    logic signed [SPEED_W-1:0] want;
    if (!rst_n) begin
      run_interval = int'(RUN_INTERVAL_RST);
      band_start   = int'(BAND_START_RST);
      band_stop    = int'(BAND_STOP_RST);
      prop_gain    = PROP_GAIN_RST;
      integ_gain   = int'(INTEG_GAIN_RST);
      deriv_gain   = DERIV_GAIN_RST;
      integ_limit  = int'(INTEG_LIMIT_RST);
      max_speed    = int'(MAX_SPEED_RST);
      countdown    = RUN_INTERVAL_RST;
      prev_err     = 0;
      err_sum      = 0;
      speed_q.delete();
      runs_predicted <= 0;
      fail_count     <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (speed_q.size() == 0) begin
          $error("speed: no item expected, got %0d", out_speed);
          fail_count <= fail_count + 1;
        end else begin
          want = speed_q.pop_front();
          if (out_speed !== want) begin
            $error("speed: expected %0d, got %0d", want, out_speed);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_RUN_INTERVAL: run_interval = int'(cfg_wdata[IVL_W-1:0]);
          REG_BAND_START:   band_start   = int'(cfg_wdata[POS_W-1:0]);
          REG_BAND_STOP:    band_stop    = int'(cfg_wdata[POS_W-1:0]);
          REG_PROP_GAIN:    prop_gain    = int'(cfg_wdata[GAIN_W-1:0]);
          REG_INTEG_GAIN:   integ_gain   = int'(cfg_wdata[GAIN_W-1:0]);
          REG_DERIV_GAIN:   deriv_gain   = int'(cfg_wdata[GAIN_W-1:0]);
          REG_INTEG_LIMIT:  integ_limit  = int'(cfg_wdata[LIM_W-1:0]);
          REG_MAX_SPEED:    max_speed    = int'(cfg_wdata[LIM_W-1:0]);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        countdown = countdown - IVL_W'(1);
        if (countdown == '0) begin
          countdown = run_interval[IVL_W-1:0];
          speed_q.push_back(loop_speed(int'(in_current_position),
                                       int'(in_target_position),
                                       in_target_valid));
          runs_predicted <= runs_predicted + 1;
        end
      end
    end
    speeds_pending <= speed_q.size();
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for pan_position_pid. Drives scheduler ticks and
// register writes, throttles the speed side, and leaves prediction and
// comparison to pan_position_pid_checker.
// ----------------------------------------------------------------------------
module tb
  import ppid_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 12;    // pipeline depth plus margin
  localparam int HOLD_CYCLES   = 150;   // long speed-side hold-off
  localparam int QUIET_LIMIT   = 4000;  // cycles with no item moving
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 105;
  localparam int ZERO_IVL_TAIL = 20;    // ticks after a zero-interval reload

  typedef struct {
    int run_interval;
    int band_start;
    int band_stop;
    int prop_gain;
    int integ_gain;
    int deriv_gain;
    int integ_limit;
    int max_speed;
  } pid_cfg_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DAT_W-1:0]      cfg_wdata;
  logic                      in_valid;
  logic                      in_stall;
  logic [POS_W-1:0]          in_current_position;
  logic [POS_W-1:0]          in_target_position;
  logic                      in_target_valid;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [SPEED_W-1:0] out_speed;

  int runs_predicted;
  int speeds_pending;
  int fail_count;

  // idle rates in percent, and requests for a long speed-side hold-off
  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int hold_req     = 0;

  // slowly moving measured position used for the tracking style of ticks
  int track_pos = 0;
  int track_tgt = 0;

  int quiet = 0;

  pan_position_pid DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_current_position (in_current_position),
    .in_target_position  (in_target_position),
    .in_target_valid     (in_target_valid),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_speed           (out_speed)
  );

  pan_position_pid_checker speed_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_current_position (in_current_position),
    .in_target_position  (in_target_position),
    .in_target_valid     (in_target_valid),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_speed           (out_speed),
    .runs_predicted      (runs_predicted),
    .speeds_pending      (speeds_pending),
    .fail_count          (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Speed-side throttle. A pending hold request takes priority: the stall is
  // held for a long stretch so that the pipeline fills and the tick side
  // backs up, while the tick driver keeps offering items.
  initial begin
    int hold_left;
    int holds_done;
    hold_left  = 0;
    holds_done = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (holds_done < hold_req) begin
        holds_done++;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < out_idle_pct);
      end
    end
  end

  // Watchdog: ends the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Offer one tick and return at the edge that takes it. Valid stays high
  // afterwards so back-to-back items need no extra assignment.
  task automatic send_tick(logic [POS_W-1:0] cur, logic [POS_W-1:0] tgt, logic tgt_ok);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_current_position <= cur;
    in_target_position  <= tgt;
    in_target_valid     <= tgt_ok;
    do @(posedge clk); while (in_stall);
  endtask

  // Mix of ticks over the whole 11-bit range, ticks within one revolution and
  // ticks where the measured position walks towards a steady target.
  task automatic random_tick();
    logic [POS_W-1:0] cur;
    logic [POS_W-1:0] tgt;
    int               step;
    if ($urandom_range(7) == 0) begin
      cur = POS_W'($urandom_range(2047));
      tgt = POS_W'($urandom_range(2047));
    end else if ($urandom_range(1) == 1) begin
      step = int'($urandom_range(30)) - 10;
      track_pos = (track_pos < track_tgt) ? track_pos + step : track_pos - step;
      track_pos = (track_pos + REV_TICKS_DEF) % REV_TICKS_DEF;
      cur = POS_W'(track_pos);
      tgt = POS_W'(track_tgt);
    end else begin
      cur = POS_W'($urandom_range(1079));
      tgt = POS_W'($urandom_range(1079));
    end
    send_tick(cur, tgt, $urandom_range(9) != 0);
  endtask

  // Random ticks until the loop has run n more times. The run count is
  // registered, so one spare tick may follow; it only moves the countdown.
  task automatic run_until(int n);
    int goal;
    goal = runs_predicted + n;
    while (runs_predicted < goal) random_tick();
  endtask

  // Stop offering ticks and wait until every speed item is out and any
  // trailing no-result ticks have drained.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (speeds_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(cfg_reg_t idx, int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DAT_W-1:0];
    @(posedge clk);
  endtask

  task automatic load_config(pid_cfg_t c);
    put_reg(REG_RUN_INTERVAL, c.run_interval);
    put_reg(REG_BAND_START,   c.band_start);
    put_reg(REG_BAND_STOP,    c.band_stop);
    put_reg(REG_PROP_GAIN,    c.prop_gain);
    put_reg(REG_INTEG_GAIN,   c.integ_gain);
    put_reg(REG_DERIV_GAIN,   c.deriv_gain);
    put_reg(REG_INTEG_LIMIT,  c.integ_limit);
    put_reg(REG_MAX_SPEED,    c.max_speed);
    cfg_we <= 1'b0;
  endtask

  // quarter low end, quarter high end, otherwise up to span
  function automatic int pick(int lo, int hi, int span);
    case ($urandom_range(3))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(span, lo);
    endcase
  endfunction

  function automatic pid_cfg_t random_config();
    pid_cfg_t c;
    c.run_interval = $urandom_range(5, 1);
    c.band_start   = pick(0, 1079, 1079);
    c.band_stop    = pick(0, 1079, 1079);
    c.prop_gain    = pick(0, 4095, 4095);
    c.integ_gain   = pick(0, 4095, 4095);
    c.deriv_gain   = pick(0, 4095, 4095);
    c.integ_limit  = pick(0, 32767, 3000);
    c.max_speed    = pick(0, 32767, 3000);
    return c;
  endfunction

  initial begin
    pid_cfg_t cfg;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= REG_RUN_INTERVAL;
    cfg_wdata           <= '0;
    in_valid            <= 1'b0;
    in_current_position <= '0;
    in_target_position  <= '0;
    in_target_valid     <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: the first run comes after 200 ticks and checks every
    // register's reset value except the interval reload.
    in_idle_pct  = 22;
    out_idle_pct = 50;
    run_until(1);
    settle();

    // Directed part: every tick runs the loop, gains and limits at the top.
    cfg = '{run_interval: 1, band_start: 205, band_stop: 860, prop_gain: 4095,
            integ_gain: 4095, deriv_gain: 4095, integ_limit: 32767, max_speed: 32767};
    load_config(cfg);
    // the countdown was reloaded with 200 at the last run; burn it down
    run_until(1);
    send_tick(11'd0,    11'd0,    1'b1);  // no error
    send_tick(11'd0,    11'd1079, 1'b1);  // wraps to -1
    send_tick(11'd1079, 11'd0,    1'b1);  // wraps to +1
    send_tick(11'd0,    11'd540,  1'b1);  // half turn, kept
    send_tick(11'd540,  11'd0,    1'b1);  // minus half turn; big negative D term
    send_tick(11'd541,  11'd0,    1'b1);  // just past half turn
    send_tick(11'd0,    11'd541,  1'b1);
    send_tick(11'd100,  11'd777,  1'b0);  // absent target counts as 0
    send_tick(11'd0,    11'd206,  1'b1);  // just inside band, snaps low
    send_tick(11'd0,    11'd531,  1'b1);  // below band middle
    send_tick(11'd0,    11'd532,  1'b1);  // band middle snaps high
    send_tick(11'd0,    11'd859,  1'b1);
    send_tick(11'd0,    11'd205,  1'b1);  // band edges are not moved
    send_tick(11'd0,    11'd860,  1'b1);
    send_tick(11'd2047, 11'd2047, 1'b1);  // out of range positions
    send_tick(11'd0,    11'd2047, 1'b1);  // wrapped error still above half turn
    send_tick(11'd2047, 11'd0,    1'b1);
    send_tick(11'd0,    11'd1700, 1'b1);
    settle();

    // Inverted band: nothing snaps. Plain P path, integrator clamped at zero.
    cfg = '{run_interval: 1, band_start: 900, band_stop: 100, prop_gain: 1024,
            integ_gain: 0, deriv_gain: 0, integ_limit: 0, max_speed: 32767};
    load_config(cfg);
    send_tick(11'd0, 11'd500,  1'b1);
    send_tick(11'd0, 11'd150,  1'b1);
    send_tick(11'd0, 11'd1079, 1'b0);

    // Random phases; idle pattern changes every third of the way through.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph * 3 / PHASES)
        0: begin
          in_idle_pct  = 22;
          out_idle_pct = 50;
        end
        1: begin
          in_idle_pct  = 50;
          out_idle_pct = 22;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      cfg = random_config();
      // a run on every tick so that a long hold-off really fills the pipe
      if (ph == 1 || ph == 9) cfg.run_interval = 1;
      load_config(cfg);
      track_tgt = $urandom_range(1079);
      if (ph == 1 || ph == 9) hold_req++;
      repeat (PHASE_ITEMS) random_tick();
    end

    // Zero interval: its run reloads 0, so the countdown wraps on the next
    // tick and the ticks that follow must yield nothing.
    in_idle_pct  = 0;
    out_idle_pct = 0;
    settle();
    cfg.run_interval = 0;
    load_config(cfg);
    run_until(1);
    repeat (ZERO_IVL_TAIL) random_tick();

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
